// File: rtl/core/tape_machine_interpreter_macros.svh
// Assertion helpers for the tape machine interpreter.
// Both sample on clock and are held off while reset is high.
`ifndef TAPE_MACHINE_INTERPRETER_MACROS_SVH
`define TAPE_MACHINE_INTERPRETER_MACROS_SVH

// same-cycle implication
`define TMI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tape machine interpreter: assertion failed");

// next-cycle implication
`define TMI_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tape machine interpreter: assertion failed");

`endif

// File: rtl/core/tmi_pkg.sv
`timescale 1ns / 1ps

package tmi_pkg;

   localparam int PROGRAM_DEPTH_DEF = 4096;
   localparam int TAPE_DEPTH_DEF    = 32768;

   // request opcodes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_RUN    = 2'd2;
   localparam logic [1:0] OP_SUPPLY = 2'd3;

   // response status
   localparam logic [2:0] ST_ACCEPTED   = 3'd0;
   localparam logic [2:0] ST_BYTE       = 3'd1;
   localparam logic [2:0] ST_FINISHED   = 3'd2;
   localparam logic [2:0] ST_NEED_INPUT = 3'd3;
   localparam logic [2:0] ST_BUDGET     = 3'd4;
   localparam logic [2:0] ST_BRACKET    = 3'd5;
   localparam logic [2:0] ST_FULL       = 3'd6;

   // stored command codes
   localparam logic [2:0] CMD_RIGHT = 3'd0;
   localparam logic [2:0] CMD_LEFT  = 3'd1;
   localparam logic [2:0] CMD_INC   = 3'd2;
   localparam logic [2:0] CMD_DEC   = 3'd3;
   localparam logic [2:0] CMD_OUT   = 3'd4;
   localparam logic [2:0] CMD_IN    = 3'd5;
   localparam logic [2:0] CMD_OPEN  = 3'd6;
   localparam logic [2:0] CMD_CLOSE = 3'd7;

   // source characters
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_INC   = 8'h2B;
   localparam logic [7:0] CH_DEC   = 8'h2D;
   localparam logic [7:0] CH_OUT   = 8'h2E;
   localparam logic [7:0] CH_IN    = 8'h2C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
   } rsp_type;

   // {hit, code}
   function automatic logic [3:0] symbol_lookup(input logic [7:0] ch);
      logic [3:0] res;
      case (ch)
         CH_RIGHT: res = {1'b1, CMD_RIGHT};
         CH_LEFT:  res = {1'b1, CMD_LEFT};
         CH_INC:   res = {1'b1, CMD_INC};
         CH_DEC:   res = {1'b1, CMD_DEC};
         CH_OUT:   res = {1'b1, CMD_OUT};
         CH_IN:    res = {1'b1, CMD_IN};
         CH_OPEN:  res = {1'b1, CMD_OPEN};
         CH_CLOSE: res = {1'b1, CMD_CLOSE};
         default:  res = 4'd0;
      endcase
      return res;
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] status, input logic [7:0] byte_val);
      rsp_type r;
      r.status   = status;
      r.out_byte = byte_val;
      return r;
   endfunction

endpackage

// File: rtl/core/tape_machine_interpreter.sv
`timescale 1ns / 1ps
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+--------------------------------
// request   | req_data, start, busy          | taken when start && !busy
// response  | rsp_data, rsp_valid            | one-cycle strobe, never stalled
// csr       | csr_we, csr_wdata              | step budget written when csr_we
//
// Load answers in the cycle after the request. Clear sweeps the tape one cell
// a cycle, then answers. Run/supply: each executed instruction passes S_CHECK
// and S_EXEC (a pointer move also S_CELL, which takes the new cell from the tape
// read port); a bracket scan walks the program symbol by symbol on the single
// program read port. A status check or a scan off the program can end the request.
// After reset the same sweep runs with busy high.
// The response strobe cannot be held off; busy is the only stall.

`include "tape_machine_interpreter_macros.svh"

module tape_machine_interpreter #(
   parameter int PROGRAM_DEPTH = tmi_pkg::PROGRAM_DEPTH_DEF,
   parameter int TAPE_DEPTH    = tmi_pkg::TAPE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tmi_pkg::req_type req_data,
   output logic             rsp_valid,
   output tmi_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);
   import tmi_pkg::*;

   localparam int PA = $clog2(PROGRAM_DEPTH);
   localparam int PL = $clog2(PROGRAM_DEPTH + 1);
   localparam int TA = $clog2(TAPE_DEPTH);

   localparam logic [PL-1:0] PC_ONE   = PL'(1);
   localparam logic [PL-1:0] LEN_FULL = PL'(PROGRAM_DEPTH);
   localparam logic [TA-1:0] CP_LAST  = TA'(TAPE_DEPTH - 1);
   localparam logic [TA-1:0] CP_ONE   = TA'(1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CLEAR = 9'b000000010,
      S_CHECK = 9'b000000100,
      S_EXEC  = 9'b000001000,
      S_CELL  = 9'b000010000,
      S_FSCAN = 9'b000100000,
      S_FWAIT = 9'b001000000,
      S_BSCAN = 9'b010000000,
      S_BWAIT = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   logic [31:0]   budget_ff;
   logic [31:0]   done_ff, done_in;
   logic [PL-1:0] len_ff, len_in;
   logic [PL-1:0] pc_ff, pc_in;
   logic [PL-1:0] idx_ff, idx_in;
   logic [PL-1:0] depth_ff, depth_in;
   logic [TA-1:0] cp_ff, cp_in;
   logic [TA-1:0] clr_ff, clr_in;
   logic [7:0]    cell_ff, cell_in;
   logic          awaiting_ff, awaiting_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [2:0]    prog_mem_ff [PROGRAM_DEPTH];
   logic [2:0]    prog_rd_ff;
   logic [7:0]    tape_mem_ff [TAPE_DEPTH];
   logic [7:0]    tape_rd_ff;

   logic          prog_we;
   logic [PA-1:0] prog_waddr;
   logic [2:0]    prog_wdata;
   logic [PA-1:0] prog_raddr;
   logic          tape_we;
   logic [TA-1:0] tape_waddr;
   logic [7:0]    tape_wdata;

   logic [3:0]    sym;
   logic [PL-1:0] idx_dec;

   assign sym     = symbol_lookup(req_data.value);
   assign idx_dec = idx_ff - PC_ONE;

   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      len_in       = len_ff;
      pc_in        = pc_ff;
      idx_in       = idx_ff;
      depth_in     = depth_ff;
      cp_in        = cp_ff;
      clr_in       = clr_ff;
      cell_in      = cell_ff;
      awaiting_in  = awaiting_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      prog_we      = 1'b0;
      prog_waddr   = len_ff[PA-1:0];
      prog_wdata   = sym[2:0];
      prog_raddr   = pc_ff[PA-1:0];
      tape_we      = 1'b0;
      tape_waddr   = cp_ff;
      tape_wdata   = cell_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  OP_CLEAR: begin
                     cp_in       = '0;
                     pc_in       = '0;
                     depth_in    = '0;
                     cell_in     = 8'd0;
                     awaiting_in = 1'b0;
                     clr_in      = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (!sym[3]) begin
                        rsp_in = make_rsp(ST_ACCEPTED, 8'd0);
                     end else if (len_ff >= LEN_FULL) begin
                        rsp_in = make_rsp(ST_FULL, 8'd0);
                     end else begin
                        prog_we = 1'b1;
                        len_in  = len_ff + PC_ONE;
                        rsp_in  = make_rsp(ST_ACCEPTED, 8'd0);
                     end
                  end
                  OP_RUN: begin
                     done_in  = '0;
                     state_in = S_CHECK;
                  end
                  default: begin
                     // supply: only takes effect when an input is pending
                     if (awaiting_ff) begin
                        tape_we     = 1'b1;
                        tape_wdata  = req_data.value;
                        cell_in     = req_data.value;
                        pc_in       = pc_ff + PC_ONE;
                        awaiting_in = 1'b0;
                     end
                     done_in  = '0;
                     state_in = S_CHECK;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
            tape_wdata = 8'd0;
            if (clr_ff == CP_LAST) begin
               state_in = S_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(ST_ACCEPTED, 8'd0);
               end
            end else begin
               clr_in = clr_ff + CP_ONE;
            end
         end
         S_CHECK: begin
            if (awaiting_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(ST_NEED_INPUT, 8'd0);
               state_in     = S_IDLE;
            end else if (pc_ff >= len_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(ST_FINISHED, 8'd0);
               state_in     = S_IDLE;
            end else if (budget_ff != 32'd0 && done_ff == budget_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(ST_BUDGET, 8'd0);
               state_in     = S_IDLE;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            done_in = done_ff + 32'd1;
            case (prog_rd_ff)
               CMD_RIGHT: begin
                  cp_in    = (cp_ff == CP_LAST) ? '0 : cp_ff + CP_ONE;
                  pc_in    = pc_ff + PC_ONE;
                  state_in = S_CELL;
               end
               CMD_LEFT: begin
                  cp_in    = (cp_ff == '0) ? CP_LAST : cp_ff - CP_ONE;
                  pc_in    = pc_ff + PC_ONE;
                  state_in = S_CELL;
               end
               CMD_INC: begin
                  cell_in    = cell_ff + 8'd1;
                  tape_we    = 1'b1;
                  tape_wdata = cell_ff + 8'd1;
                  pc_in      = pc_ff + PC_ONE;
                  state_in   = S_CHECK;
               end
               CMD_DEC: begin
                  cell_in    = cell_ff - 8'd1;
                  tape_we    = 1'b1;
                  tape_wdata = cell_ff - 8'd1;
                  pc_in      = pc_ff + PC_ONE;
                  state_in   = S_CHECK;
               end
               CMD_OUT: begin
                  pc_in        = pc_ff + PC_ONE;
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(ST_BYTE, cell_ff);
                  state_in     = S_IDLE;
               end
               CMD_IN: begin
                  awaiting_in  = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(ST_NEED_INPUT, 8'd0);
                  state_in     = S_IDLE;
               end
               CMD_OPEN: begin
                  if (cell_ff == 8'd0) begin
                     depth_in = PC_ONE;
                     idx_in   = pc_ff + PC_ONE;
                     state_in = S_FSCAN;
                  end else begin
                     pc_in    = pc_ff + PC_ONE;
                     state_in = S_CHECK;
                  end
               end
               default: begin
                  if (cell_ff != 8'd0) begin
                     depth_in = PC_ONE;
                     idx_in   = pc_ff;
                     state_in = S_BSCAN;
                  end else begin
                     pc_in    = pc_ff + PC_ONE;
                     state_in = S_CHECK;
                  end
               end
            endcase
         end
         S_CELL: begin
            // tape read of the new cell was issued on the move
            cell_in  = tape_rd_ff;
            state_in = S_CHECK;
         end
         S_FSCAN: begin
            prog_raddr = idx_ff[PA-1:0];
            if (idx_ff >= len_ff) begin
               depth_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(ST_BRACKET, 8'd0);
               state_in     = S_IDLE;
            end else begin
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: begin
            state_in = S_FSCAN;
            idx_in   = idx_ff + PC_ONE;
            if (prog_rd_ff == CMD_OPEN) begin
               depth_in = depth_ff + PC_ONE;
            end else if (prog_rd_ff == CMD_CLOSE) begin
               if (depth_ff == PC_ONE) begin
                  depth_in = '0;
                  pc_in    = idx_ff + PC_ONE;
                  state_in = S_CHECK;
               end else begin
                  depth_in = depth_ff - PC_ONE;
               end
            end
         end
         S_BSCAN: begin
            prog_raddr = idx_dec[PA-1:0];
            if (idx_ff == '0) begin
               depth_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(ST_BRACKET, 8'd0);
               state_in     = S_IDLE;
            end else begin
               idx_in   = idx_dec;
               state_in = S_BWAIT;
            end
         end
         S_BWAIT: begin
            state_in = S_BSCAN;
            if (prog_rd_ff == CMD_CLOSE) begin
               depth_in = depth_ff + PC_ONE;
            end else if (prog_rd_ff == CMD_OPEN) begin
               if (depth_ff == PC_ONE) begin
                  depth_in = '0;
                  pc_in    = idx_ff + PC_ONE;
                  state_in = S_CHECK;
               end else begin
                  depth_in = depth_ff - PC_ONE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         budget_ff    <= 32'd0;
         done_ff      <= 32'd0;
         len_ff       <= '0;
         pc_ff        <= '0;
         idx_ff       <= '0;
         depth_ff     <= '0;
         cp_ff        <= '0;
         clr_ff       <= '0;
         cell_ff      <= 8'd0;
         awaiting_ff  <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            budget_ff <= csr_wdata;
         end
         done_ff      <= done_in;
         len_ff       <= len_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         depth_ff     <= depth_in;
         cp_ff        <= cp_in;
         clr_ff       <= clr_in;
         cell_ff      <= cell_in;
         awaiting_ff  <= awaiting_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem_ff[prog_waddr] <= prog_wdata;
      end
      prog_rd_ff <= prog_mem_ff[prog_raddr];
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem_ff[tape_waddr] <= tape_wdata;
      end
      tape_rd_ff <= tape_mem_ff[cp_in];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every accepted request either starts work or answers on the next cycle
   `TMI_ASSERT_NXT(a_req_progress, start && !busy, busy || rsp_valid)
   // only an output command carries a byte
   `TMI_ASSERT_IMP(a_byte_only_out, rsp_valid && rsp_data.status != ST_BYTE,
                   rsp_data.out_byte == 8'd0)
   // program counter never runs past the loaded program
   `TMI_ASSERT_IMP(a_pc_in_range, 1'b1, pc_ff <= len_ff)
   // waiting for input blocks any instruction fetch
   `TMI_ASSERT_IMP(a_wait_no_exec, awaiting_ff, state_ff != S_EXEC)

endmodule
